FILE: hw/rtl/mlbs_pkg.sv
// shared types and constants for the multi-led blink scheduler
`default_nettype none
package mlbs_pkg;

	// fixed field widths of the item and result beats
	localparam int unsigned TICKS_W   = 16;
	localparam int unsigned INDEX_W   = 2;
	localparam int unsigned OUT_BITS  = 4;

	// defaults for the top level parameters
	localparam int unsigned NUM_LEDS_DEF    = 4;
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	// item kinds
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_SET   = 2'd1,
		KIND_START = 2'd2,
		KIND_STOP  = 2'd3
	} kind_t;

	// input beat
	typedef struct packed {
		kind_t                kind;
		logic [INDEX_W-1:0]   led_index;
		logic                 level;
		logic [TICKS_W-1:0]   on_ticks;
		logic [TICKS_W-1:0]   period_ticks;
	} item_t;

	// result beat
	typedef struct packed {
		logic [OUT_BITS-1:0] led_levels;
		logic [OUT_BITS-1:0] blinking_mask;
	} result_t;

	// command broadcast from the top level to every channel
	typedef struct packed {
		logic               en;
		kind_t              kind;
		logic               level;
		logic [TICKS_W-1:0] on_ticks;
		logic [TICKS_W-1:0] period_ticks;
	} chan_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mlbs_channel.sv
// one led channel: level, blink lengths and tick counters
`default_nettype none
module mlbs_channel #(
	parameter int unsigned COUNT_WIDTH = mlbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mlbs_pkg::chan_cmd_t  cmd,
	input  wire logic                 sel,
	output logic                      level,
	output logic                      blinking
);
	import mlbs_pkg::*;

	logic                   level_q;
	logic [COUNT_WIDTH-1:0] on_len_q;
	logic [COUNT_WIDTH-1:0] period_len_q;
	logic [COUNT_WIDTH-1:0] period_cnt_q;
	logic [COUNT_WIDTH-1:0] on_cnt_q;

	logic [COUNT_WIDTH-1:0] on_in;
	logic [COUNT_WIDTH-1:0] period_in;

	// fit the 16-bit tick fields to the counter width
	if (COUNT_WIDTH == TICKS_W) begin : g_same
		assign on_in     = cmd.on_ticks;
		assign period_in = cmd.period_ticks;
	end else if (COUNT_WIDTH > TICKS_W) begin : g_wide
		assign on_in     = {{(COUNT_WIDTH - TICKS_W){1'b0}}, cmd.on_ticks};
		assign period_in = {{(COUNT_WIDTH - TICKS_W){1'b0}}, cmd.period_ticks};
	end else begin : g_narrow
		assign on_in     = cmd.on_ticks[COUNT_WIDTH-1:0];
		assign period_in = cmd.period_ticks[COUNT_WIDTH-1:0];
	end

	// tick update: period counter wraps by compare, then the on counter
	logic                   active;
	logic [COUNT_WIDTH-1:0] period_eff;
	logic [COUNT_WIDTH:0]   period_inc;
	logic [COUNT_WIDTH:0]   on_inc;
	logic [COUNT_WIDTH-1:0] period_cnt_nx;
	logic [COUNT_WIDTH-1:0] on_cnt_nx;
	logic                   level_mid;
	logic                   level_tick;

	always_comb begin
		active     = (on_len_q != '0);
		period_eff = (period_len_q == '0) ? COUNT_WIDTH'(1) : period_len_q;
		period_inc = {1'b0, period_cnt_q} + (COUNT_WIDTH + 1)'(1);
		period_cnt_nx = (period_inc >= {1'b0, period_eff}) ? '0
			: period_inc[COUNT_WIDTH-1:0];
		level_mid  = (period_cnt_nx == '0) ? 1'b1 : level_q;
		on_inc     = {1'b0, on_cnt_q} + (COUNT_WIDTH + 1)'(1);
		on_cnt_nx  = on_cnt_q;
		level_tick = level_mid;
		if (level_mid) begin
			on_cnt_nx = (on_inc >= {1'b0, on_len_q}) ? '0 : on_inc[COUNT_WIDTH-1:0];
			if (on_cnt_nx == '0) begin
				level_tick = 1'b0;
			end
		end
	end

	// control state: level and on length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= 1'b0;
			on_len_q <= '0;
		end else if (cmd.en) begin
			case (cmd.kind)
				KIND_TICK: begin
					if (active) begin
						level_q <= level_tick;
					end
				end
				KIND_SET: begin
					if (sel) begin
						level_q <= cmd.level;
					end
				end
				KIND_START: begin
					if (sel) begin
						level_q  <= 1'b0;
						on_len_q <= on_in;
					end
				end
				KIND_STOP: begin
					if (sel) begin
						on_len_q <= '0;
					end
				end
				default: begin
					level_q <= level_q;
				end
			endcase
		end
	end

	// period length and counters, only read while blinking
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.kind == KIND_TICK) begin
				if (active) begin
					period_cnt_q <= period_cnt_nx;
					on_cnt_q     <= on_cnt_nx;
				end
			end else if (cmd.kind == KIND_START && sel) begin
				period_len_q <= period_in;
				period_cnt_q <= '0;
				on_cnt_q     <= '0;
			end
		end
	end

	assign level    = level_q;
	assign blinking = active;

endmodule
`default_nettype wire

FILE: hw/rtl/multi_led_blink_scheduler.sv
// top level of the multi-led blink scheduler
//
//  channel  dir  beat      fields
//  item     in   item_t    kind, led_index, level, on_ticks, period_ticks
//  result   out  result_t  led_levels, blinking_mask
//
// one result beat per item beat, one item per cycle sustained while result_ready stays high
// an accepted item passes the item register, then the channel state, which is shown as the result
// the item stage holds while the result beat waits on result_ready
// reset clears levels and on lengths; all leds off and not blinking
`default_nettype none
module multi_led_blink_scheduler #(
	parameter int unsigned NUM_LEDS    = mlbs_pkg::NUM_LEDS_DEF,
	parameter int unsigned COUNT_WIDTH = mlbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire mlbs_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output mlbs_pkg::result_t      result
);
	import mlbs_pkg::*;

	logic    item_vld_s1;
	item_t   item_s1;
	logic    advance;
	logic    res_vld_q;
	result_t res_beat;

	assign advance    = item_vld_s1 && (!res_vld_q || result_ready);
	assign item_ready = !item_vld_s1 || advance;

	// item stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (item_ready) begin
			item_vld_s1 <= item_valid;
		end
	end

	// item stage payload
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// command broadcast to the channels
	chan_cmd_t cmd;
	always_comb begin
		cmd.en           = advance;
		cmd.kind         = item_s1.kind;
		cmd.level        = item_s1.level;
		cmd.on_ticks     = item_s1.on_ticks;
		cmd.period_ticks = item_s1.period_ticks;
	end

	logic [NUM_LEDS-1:0] lvl_now;
	logic [NUM_LEDS-1:0] blk_now;

	for (genvar i = 0; i < NUM_LEDS; i++) begin : g_chan
		logic sel;
		assign sel = (32'(item_s1.led_index) == i);
		mlbs_channel #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.sel     (sel),
			.level   (lvl_now[i]),
			.blinking(blk_now[i])
		);
	end

	// result beat reads the updated channel state, low four leds only
	logic [OUT_BITS-1:0] lvl_nx;
	logic [OUT_BITS-1:0] blk_nx;

	for (genvar j = 0; j < OUT_BITS; j++) begin : g_out
		if (j < NUM_LEDS) begin : g_led
			assign lvl_nx[j] = lvl_now[j];
			assign blk_nx[j] = blk_now[j];
		end else begin : g_none
			assign lvl_nx[j] = 1'b0;
			assign blk_nx[j] = 1'b0;
		end
	end

	// result valid: channel state lands on the same edge, so the beat
	// is taken from the channel outputs while it is shown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= 1'b1;
		end else if (result_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_comb begin
		res_beat.led_levels    = lvl_nx;
		res_beat.blinking_mask = blk_nx;
	end

	assign result_valid = res_vld_q;
	assign result       = res_beat;

`ifndef ASSERT_OFF
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_vld_s1 && !advance |=> item_vld_s1 && $stable(item_s1))
		else $error("item stage changed while stalled");

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("no result after an item advanced");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == KIND_STOP && item_s1.led_index == '0
		|=> !result.blinking_mask[0])
		else $error("stop left led 0 blinking");

	a_set_level: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == KIND_SET && item_s1.led_index == '0
		|=> result.led_levels[0] == $past(item_s1.level))
		else $error("static level not applied to led 0");

	a_start_off: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == KIND_START && item_s1.led_index == '0
		|=> !result.led_levels[0])
		else $error("start left led 0 on");
`endif

endmodule
`default_nettype wire
